// ===== src/hlm_pkg.sv =====
package hlm_pkg;

  localparam int NUM_SLOTS  = 32;
  localparam int SLOT_W     = 5;
  localparam int COUNT_W    = 6;
  localparam int TIME_W     = 32;
  localparam int INTERVAL_W = 16;
  localparam int LIMIT_W    = INTERVAL_W + 1;

  localparam logic [COUNT_W-1:0] SLOT_LIMIT = COUNT_W'(NUM_SLOTS);

  localparam logic MODE_PING  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic REG_CHECK_INTERVAL = 1'b0;
  localparam logic REG_NODE_COUNT     = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  // Commands broadcast from the sequencer to every cell.
  typedef struct packed {
    logic ping;
    logic query;
    logic shift;
  } cell_cmd_t;

endpackage

// ===== src/hlm_cell.sv =====
module hlm_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  hlm_pkg::cell_cmd_t        cmd,
  input  logic [hlm_pkg::SLOT_W-1:0]  slot_id,
  input  logic [hlm_pkg::COUNT_W-1:0] active_count,
  input  logic [hlm_pkg::TIME_W-1:0]  timestamp,
  input  logic [hlm_pkg::SLOT_W-1:0]  node_index,
  input  logic [hlm_pkg::LIMIT_W-1:0] limit,
  input  logic                      flag_in,
  output logic                      flag
);
  import hlm_pkg::*;

  logic [TIME_W-1:0] last_seen;
  logic [TIME_W-1:0] age;
  logic              active;
  logic              dead;

  assign active = {1'b0, slot_id} < active_count;
  assign age    = timestamp - last_seen;
  // A timestamp earlier than the last ping gives a negative age: never dead.
  assign dead   = active && (timestamp >= last_seen) &&
                  (age >= {{(TIME_W-LIMIT_W){1'b0}}, limit});

  always_ff @(posedge clk) begin
    if (rst) begin
      last_seen <= '0;
    end else if (cmd.ping && active && (node_index == slot_id)) begin
      last_seen <= timestamp;
    end
  end

  // The dead flags move one cell towards slot 0 on every shift.
  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= 1'b0;
    end else if (cmd.query) begin
      flag <= dead;
    end else if (cmd.shift) begin
      flag <= flag_in;
    end
  end

endmodule

// ===== src/hlm_ctrl.sv =====
module hlm_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          mode,
  input  logic [hlm_pkg::NUM_SLOTS-1:0] flags,
  output hlm_pkg::cell_cmd_t            cmd,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hlm_pkg::SLOT_W-1:0]    dead_node,
  output logic                          none_dead,
  output logic                          last
);
  import hlm_pkg::*;

  state_t            state, state_next;
  logic [SLOT_W-1:0] pos, pos_next;
  logic              found, found_next;
  logic              emit;
  logic [SLOT_W-1:0] emit_node;
  logic              emit_none;
  logic              emit_last;
  logic              out_free;
  logic              any_flag;
  logic              flag_above;

  assign out_free   = !out_valid || !out_stall;
  assign any_flag   = |flags;
  assign flag_above = |flags[NUM_SLOTS-1:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pos   <= '0;
      found <= 1'b0;
    end else begin
      state <= state_next;
      pos   <= pos_next;
      found <= found_next;
    end
  end

  always_comb begin
    state_next = state;
    pos_next   = pos;
    found_next = found;
    cmd        = '0;
    in_stall   = 1'b1;
    emit       = 1'b0;
    emit_node  = '0;
    emit_none  = 1'b0;
    emit_last  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (mode == MODE_QUERY) begin
            cmd.query  = 1'b1;
            pos_next   = '0;
            found_next = 1'b0;
            state_next = ST_SCAN;
          end else begin
            cmd.ping = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (!any_flag) begin
          // Nothing left in the chain; an empty query still owes one word.
          if (found) begin
            state_next = ST_IDLE;
          end else if (out_free) begin
            emit       = 1'b1;
            emit_none  = 1'b1;
            emit_last  = 1'b1;
            state_next = ST_IDLE;
          end
        end else if (flags[0]) begin
          if (out_free) begin
            emit       = 1'b1;
            emit_node  = pos;
            emit_last  = !flag_above;
            found_next = 1'b1;
            cmd.shift  = 1'b1;
            pos_next   = pos + 1'b1;
          end
        end else begin
          cmd.shift = 1'b1;
          pos_next  = pos + 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      dead_node <= emit_node;
      none_dead <= emit_none;
      last      <= emit_last;
    end
  end

endmodule

// ===== src/heartbeat_liveness_monitor_core.sv =====
// Heartbeat watchdog over 32 node slots, each slot a cell holding its last
// ping time. Ping words are accepted back to back. A query word loads every
// cell's dead flag at once, then the flags shift one cell per cycle towards
// the output, pausing while a dead flag waits on a stalled output; a query
// keeps the input stalled until the scan past the highest dead slot ends.
// Results leave in ascending slot order from an output register; last marks
// the final word of a query, and a query with no dead node returns one word
// with none_dead and last set.
// Configuration writes are expected only while the block is idle.
module heartbeat_liveness_monitor_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic                           cfg_index,
  input  logic [hlm_pkg::INTERVAL_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           mode,
  input  logic [hlm_pkg::TIME_W-1:0]     timestamp,
  input  logic [hlm_pkg::SLOT_W-1:0]     node_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [hlm_pkg::SLOT_W-1:0]     dead_node,
  output logic                           none_dead,
  output logic                           last
);
  import hlm_pkg::*;

  logic [INTERVAL_W-1:0] check_interval;
  logic [COUNT_W-1:0]    node_count;
  logic [COUNT_W-1:0]    active_count;
  logic [LIMIT_W-1:0]    limit;
  logic [NUM_SLOTS-1:0]  flags;
  logic [NUM_SLOTS:0]    flag_chain;
  cell_cmd_t             cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      check_interval <= '0;
      node_count     <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CHECK_INTERVAL: check_interval <= cfg_data;
        REG_NODE_COUNT:     node_count     <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign active_count = (node_count > SLOT_LIMIT) ? SLOT_LIMIT : node_count;
  assign limit        = {check_interval, 1'b0};

  assign flag_chain[NUM_SLOTS]   = 1'b0;
  assign flag_chain[NUM_SLOTS-1:0] = flags;

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    hlm_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .cmd          (cmd),
      .slot_id      (SLOT_W'(i)),
      .active_count (active_count),
      .timestamp    (timestamp),
      .node_index   (node_index),
      .limit        (limit),
      .flag_in      (flag_chain[i+1]),
      .flag         (flags[i])
    );
  end

  hlm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .flags     (flags),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dead_node (dead_node),
    .none_dead (none_dead),
    .last      (last)
  );

endmodule

// ===== test/tb_heartbeat_liveness_monitor_core.sv =====
`timescale 1ns / 1ps

module tb_heartbeat_liveness_monitor_core;
  import hlm_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT = 3000;

  typedef struct packed {
    logic                kind;
    logic [TIME_W-1:0]   ts;
    logic [SLOT_W-1:0]   slot;
  } hb_word_t;

  typedef struct packed {
    logic [SLOT_W-1:0] node;
    logic              empty;
    logic              fin;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic cfg_index = REG_CHECK_INTERVAL;
  logic [INTERVAL_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic mode = MODE_PING;
  logic [TIME_W-1:0] timestamp = '0;
  logic [SLOT_W-1:0] node_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [SLOT_W-1:0] dead_node;
  logic none_dead;
  logic last;

  heartbeat_liveness_monitor_core u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .timestamp  (timestamp),
    .node_index (node_index),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .dead_node  (dead_node),
    .none_dead  (none_dead),
    .last       (last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow of the block's state and registers.
  logic [TIME_W-1:0]     seen_time [NUM_SLOTS];
  logic [INTERVAL_W-1:0] intv_shadow = '0;
  logic [COUNT_W-1:0]    cnt_shadow = '0;

  hb_word_t heartbeat_q[$];
  verdict_t verdict_q[$];
  hb_word_t cur_word;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int err_cnt = 0;
  int ping_cnt = 0;
  int query_cnt = 0;
  int dead_words = 0;
  int empty_words = 0;
  int reg_writes = 0;
  int quiet_cycles = 0;
  logic [TIME_W-1:0] now_ts = '0;

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) seen_time[i] = '0;
  end

  task automatic report_err(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    err_cnt++;
  endtask

  // Applies one accepted word to the shadow state and queues the verdicts it causes.
  task automatic scan_heartbeats(input hb_word_t w);
    int n;
    int hits;
    logic [LIMIT_W-1:0] lim;
    verdict_t v;
    n = (cnt_shadow > NUM_SLOTS) ? NUM_SLOTS : int'(cnt_shadow);
    lim = {intv_shadow, 1'b0};
    hits = 0;
    if (w.kind == MODE_PING) begin
      ping_cnt++;
      if (int'(w.slot) < n) seen_time[w.slot] = w.ts;
    end else begin
      query_cnt++;
      for (int i = 0; i < n; i++) begin
        if (w.ts >= seen_time[i] && (w.ts - seen_time[i]) >= TIME_W'(lim)) begin
          v.node = SLOT_W'(i);
          v.empty = 1'b0;
          v.fin = 1'b0;
          verdict_q.insert(verdict_q.size(), v);
          hits++;
        end
      end
      if (hits == 0) begin
        v.node = '0;
        v.empty = 1'b1;
        v.fin = 1'b1;
        verdict_q.insert(verdict_q.size(), v);
      end else begin
        verdict_q[verdict_q.size() - 1].fin = 1'b1;
      end
    end
  endtask

  always @(posedge clk) begin : drive_words
    logic take_next;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      take_next = !in_valid;
      if (in_valid && !in_stall) begin
        scan_heartbeats(cur_word);
        take_next = 1'b1;
      end
      if (take_next) begin
        if (heartbeat_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_word = heartbeat_q.pop_front();
          in_valid <= 1'b1;
          mode <= cur_word.kind;
          timestamp <= cur_word.ts;
          node_index <= cur_word.slot;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // The long hold is counted here so that the sender keeps offering meanwhile.
  always @(posedge clk) begin
    if (hold_ack != hold_req) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : check_words
    verdict_t want;
    if (!rst && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        report_err($sformatf("unexpected word dead_node=%0d none_dead=%0b last=%0b",
                             dead_node, none_dead, last));
      end else begin
        want = verdict_q.pop_front();
        if (dead_node !== want.node)
          report_err($sformatf("dead_node %0d, expected %0d", dead_node, want.node));
        if (none_dead !== want.empty)
          report_err($sformatf("none_dead %0b, expected %0b", none_dead, want.empty));
        if (last !== want.fin)
          report_err($sformatf("last %0b, expected %0b", last, want.fin));
        if (want.empty) empty_words++;
        else dead_words++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog expired: no word moved for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_word(input logic kind, input logic [TIME_W-1:0] ts,
                           input logic [SLOT_W-1:0] slot);
    hb_word_t w;
    w.kind = kind;
    w.ts = ts;
    w.slot = slot;
    heartbeat_q.insert(heartbeat_q.size(), w);
  endtask

  // Waits until every word has gone in and every verdict has come out, then lets
  // a trailing ping finish.
  task automatic settle();
    while (heartbeat_q.size() != 0 || in_valid || verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [INTERVAL_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == REG_CHECK_INTERVAL) intv_shadow = data;
    else cnt_shadow = data[COUNT_W-1:0];
    reg_writes++;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Mostly pings to slots in use with time moving forward on the scale of the
  // interval, so that nodes both survive and die; the rest is noise.
  task automatic fill_random(input int items);
    int r;
    int span;
    int n;
    logic kind;
    logic [SLOT_W-1:0] slot;
    n = (cnt_shadow > NUM_SLOTS) ? NUM_SLOTS : int'(cnt_shadow);
    span = (intv_shadow == 0) ? 4 : int'(intv_shadow);
    for (int k = 0; k < items; k++) begin
      r = $urandom_range(99);
      kind = ($urandom_range(3) == 0) ? MODE_QUERY : MODE_PING;
      if (n > 0 && $urandom_range(99) < 85) slot = SLOT_W'($urandom_range(n - 1));
      else slot = SLOT_W'($urandom_range(NUM_SLOTS - 1));
      if (r < 5) begin
        push_word(1'($urandom_range(1)), $urandom, SLOT_W'($urandom));
      end else begin
        if (r < 9) now_ts = now_ts - TIME_W'($urandom_range(2 * span));
        else now_ts = now_ts + TIME_W'($urandom_range(span));
        push_word(kind, now_ts, slot);
      end
    end
  endtask

  initial begin
    logic [INTERVAL_W-1:0] intv;
    logic [COUNT_W-1:0] cnt;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Out of reset no slot is in use: the ping is dropped and the query is empty.
    push_word(MODE_PING, 32'd5, 5'd0);
    push_word(MODE_QUERY, 32'd5, 5'd31);
    settle();

    // Zero interval with an oversized count: every slot at age zero is dead.
    write_reg(REG_CHECK_INTERVAL, 16'h0000);
    write_reg(REG_NODE_COUNT, 16'hFFFF);
    push_word(MODE_QUERY, 32'd0, 5'd0);
    push_word(MODE_PING, 32'd100, 5'd31);
    push_word(MODE_PING, 32'd100, 5'd0);
    push_word(MODE_QUERY, 32'd50, 5'd0);
    settle();

    // Widest interval: one second short of the limit, then exactly on it.
    write_reg(REG_CHECK_INTERVAL, 16'hFFFF);
    write_reg(REG_NODE_COUNT, 16'd3);
    push_word(MODE_PING, 32'd1000, 5'd0);
    push_word(MODE_PING, 32'd1000, 5'd1);
    push_word(MODE_PING, 32'd1000, 5'd2);
    push_word(MODE_PING, 32'd1000, 5'd3);
    push_word(MODE_QUERY, 32'd1000 + 32'd131069, 5'd0);
    push_word(MODE_QUERY, 32'd1000 + 32'd131070, 5'd0);
    push_word(MODE_PING, 32'hFFFF_FFFF, 5'd1);
    push_word(MODE_QUERY, 32'hFFFF_FFFF, 5'd0);
    settle();

    write_reg(REG_CHECK_INTERVAL, 16'd1);
    write_reg(REG_NODE_COUNT, 16'd1);
    push_word(MODE_PING, 32'd10, 5'd0);
    push_word(MODE_QUERY, 32'd11, 5'd0);
    push_word(MODE_QUERY, 32'd12, 5'd0);
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(4))
        0: intv = '0;
        1: intv = '1;
        2: intv = INTERVAL_W'($urandom_range(1, 8));
        default: intv = INTERVAL_W'($urandom);
      endcase
      case ($urandom_range(5))
        0: cnt = COUNT_W'(NUM_SLOTS);
        1: cnt = COUNT_W'($urandom_range(NUM_SLOTS + 1, 63));
        2: cnt = COUNT_W'($urandom_range(1, 4));
        default: cnt = COUNT_W'($urandom_range(NUM_SLOTS));
      endcase
      write_reg(REG_CHECK_INTERVAL, intv);
      write_reg(REG_NODE_COUNT, (INTERVAL_W'($urandom) & 16'hFFC0) | INTERVAL_W'(cnt));
      case (ph / 2)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 76; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 76; end
        default: begin send_idle_pct = 14; stall_pct = 14; end
      endcase
      now_ts = ($urandom_range(3) == 0) ? TIME_W'($urandom_range(1000)) : TIME_W'($urandom);
      if (ph == 1) hold_req++;
      fill_random(55);
      settle();
    end

    if (verdict_q.size() != 0)
      report_err($sformatf("%0d expected words never arrived", verdict_q.size()));
    $display("Ran %0d pings and %0d queries across %0d register writes.",
             ping_cnt, query_cnt, reg_writes);
    $display("Checked %0d dead-node words and %0d empty-query words.", dead_words, empty_words);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/hlm_pkg.sv
src/hlm_cell.sv
src/hlm_ctrl.sv
src/heartbeat_liveness_monitor_core.sv
test/tb_heartbeat_liveness_monitor_core.sv
